[hw/rtl/scba_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the size-class block allocator.
// Used by every module of the block; depends on nothing else.
package scba_pkg;

    localparam int NUM_CLASSES      = 12;
    localparam int BLOCKS_PER_CLASS = 256;
    localparam int MIN_BLOCK_BYTES  = 32;
    localparam int TOTAL_BLOCKS     = NUM_CLASSES * BLOCKS_PER_CLASS;

    localparam int HANDLE_W = 12;
    localparam int CLS_W    = 4;
    localparam int IDX_W    = $clog2(BLOCKS_PER_CLASS);
    localparam int CNT_W    = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int SIZE_W   = 17;
    localparam int TICK_W   = 32;
    localparam int USAGE_W  = 25;
    localparam int STAT_W   = 3;
    localparam int TOTAL_W  = 32;

    // stream payload layout
    localparam int IN_W    = 96;
    localparam int OUT_W   = 136;
    localparam int I_SIZE  = 0;
    localparam int I_HDL   = I_SIZE + SIZE_W;
    localparam int I_DL    = I_HDL + HANDLE_W;
    localparam int I_NOW   = I_DL + TICK_W;
    localparam int O_STAT  = 0;
    localparam int O_GRANT = O_STAT + STAT_W;
    localparam int O_CLS   = O_GRANT + HANDLE_W;
    localparam int O_MISS  = O_CLS + CLS_W;
    localparam int O_USE   = O_MISS + 1;
    localparam int O_PEAK  = O_USE + USAGE_W;
    localparam int O_FAIL  = O_PEAK + USAGE_W;
    localparam int O_MTOT  = O_FAIL + TOTAL_W;
    localparam int O_END   = O_MTOT + TOTAL_W;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BIG    = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD    = 3'd4;
    localparam logic [STAT_W-1:0] ST_DOUBLE = 3'd5;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic {S_IDLE, S_EXEC} ctl_state_t;

    typedef struct packed {
        logic                rd_en;
        logic [HANDLE_W-1:0] rd_addr;
        logic                link_we;
        logic [HANDLE_W-1:0] link_addr;
        logic [HANDLE_W-1:0] link_wdata;
        logic                busy_we;
        logic [HANDLE_W-1:0] busy_addr;
        logic                busy_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] link_rdata;
        logic                busy_rdata;
        logic                clearing;
    } mem_rsp_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  miss_total;
        logic [TOTAL_W-1:0]  failure_total;
        logic [USAGE_W-1:0]  peak_bytes;
        logic [USAGE_W-1:0]  usage_bytes;
        logic                deadline_missed;
        logic [CLS_W-1:0]    class_index;
        logic [HANDLE_W-1:0] granted_handle;
        logic [STAT_W-1:0]   status;
    } result_t;

    function automatic logic [USAGE_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        return USAGE_W'(MIN_BLOCK_BYTES) << c;
    endfunction

    // smallest class whose block holds the request
    function automatic logic [CLS_W-1:0] pick_class(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] pick;
        pick = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (class_bytes(CLS_W'(i)) >= USAGE_W'(size))
            begin
                pick = CLS_W'(i);
            end
        end
        return pick;
    endfunction

endpackage

[hw/rtl/scba_block_mem.sv]
`timescale 1ns / 1ps
// Per-block storage: next-link memory and in-use map, both with synchronous (registered) reads.
// Runs the in-use map clearing sweep after reset. Depends on scba_pkg.
module scba_block_mem
(
    input  logic               clk,
    input  logic               rst_n,
    input  scba_pkg::mem_req_t req,
    output scba_pkg::mem_rsp_t rsp
);

    logic [scba_pkg::HANDLE_W-1:0] link_mem [scba_pkg::TOTAL_BLOCKS];
    logic                          busy_mem [scba_pkg::TOTAL_BLOCKS];

    logic [scba_pkg::HANDLE_W-1:0] link_rd_reg;
    logic                          busy_rd_reg;
    logic                          clearing_reg;
    logic                          clearing_next;
    logic [scba_pkg::HANDLE_W-1:0] clr_cnt_reg;
    logic [scba_pkg::HANDLE_W-1:0] clr_cnt_next;

    logic                          busy_we;
    logic [scba_pkg::HANDLE_W-1:0] busy_addr;
    logic                          busy_wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (clr_cnt_reg == scba_pkg::HANDLE_W'(scba_pkg::TOTAL_BLOCKS - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // sweep owns the write port until it ends
    assign busy_we    = clearing_reg | req.busy_we;
    assign busy_addr  = clearing_reg ? clr_cnt_reg : req.busy_addr;
    assign busy_wdata = clearing_reg ? 1'b0 : req.busy_wdata;

    always_ff @(posedge clk)
    begin
        if (req.link_we)
        begin
            link_mem[req.link_addr] <= req.link_wdata;
        end
        if (req.rd_en)
        begin
            link_rd_reg <= link_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_we)
        begin
            busy_mem[busy_addr] <= busy_wdata;
        end
        if (req.rd_en)
        begin
            busy_rd_reg <= busy_mem[req.rd_addr];
        end
    end

    assign rsp.link_rdata = link_rd_reg;
    assign rsp.busy_rdata = busy_rd_reg;
    assign rsp.clearing   = clearing_reg;

endmodule

[hw/rtl/scba_ctrl.sv]
`timescale 1ns / 1ps
// Request sequencer: class lookup, per-class list heads and counts, usage and
// failure statistics, read-modify-write of the block memory. Depends on scba_pkg.
module scba_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [scba_pkg::SIZE_W-1:0]   req_size,
    input  logic [scba_pkg::HANDLE_W-1:0] handle,
    input  logic [scba_pkg::TICK_W-1:0]   deadline,
    input  logic [scba_pkg::TICK_W-1:0]   now_tick,
    output scba_pkg::mem_req_t            mem_req,
    input  scba_pkg::mem_rsp_t            mem_rsp,
    input  logic                          slot_free,
    output logic                          res_valid,
    output scba_pkg::result_t             res
);

    scba_pkg::ctl_state_t state_reg;
    scba_pkg::ctl_state_t state_next;

    logic [scba_pkg::HANDLE_W-1:0] head_reg  [scba_pkg::NUM_CLASSES];
    logic [scba_pkg::CNT_W-1:0]    rcnt_reg  [scba_pkg::NUM_CLASSES];
    logic [scba_pkg::CNT_W-1:0]    fresh_reg [scba_pkg::NUM_CLASSES];

    logic [scba_pkg::USAGE_W-1:0]  usage_reg;
    logic [scba_pkg::USAGE_W-1:0]  usage_next;
    logic [scba_pkg::USAGE_W-1:0]  peak_reg;
    logic [scba_pkg::USAGE_W-1:0]  peak_next;
    logic [scba_pkg::TOTAL_W-1:0]  fail_reg;
    logic [scba_pkg::TOTAL_W-1:0]  fail_next;
    logic [scba_pkg::TOTAL_W-1:0]  miss_reg;
    logic [scba_pkg::TOTAL_W-1:0]  miss_next;

    // request latched at accept
    logic                          kind_reg;
    logic                          zero_reg;
    logic                          big_reg;
    logic                          bad_reg;
    logic                          late_reg;
    logic [scba_pkg::CLS_W-1:0]    cls_reg;
    logic [scba_pkg::HANDLE_W-1:0] h_reg;
    logic [scba_pkg::HANDLE_W-1:0] head_l_reg;
    logic [scba_pkg::CNT_W-1:0]    rcnt_l_reg;
    logic [scba_pkg::CNT_W-1:0]    fresh_l_reg;

    logic                          accept;
    logic                          done;
    logic                          zero_in;
    logic                          big_in;
    logic                          bad_in;
    logic                          late_in;
    logic [scba_pkg::CLS_W-1:0]    cls_in;
    logic [scba_pkg::HANDLE_W-1:0] head_in;

    logic                          ok_alloc;
    logic                          ok_free;
    logic                          fail_inc;
    logic [scba_pkg::STAT_W-1:0]   status;
    logic [scba_pkg::HANDLE_W-1:0] grant;
    logic [scba_pkg::HANDLE_W-1:0] new_head;
    logic [scba_pkg::CNT_W-1:0]    new_rcnt;
    logic [scba_pkg::CNT_W-1:0]    new_fresh;

    assign in_ready = (state_reg == scba_pkg::S_IDLE) && !mem_rsp.clearing;
    assign accept   = in_valid && in_ready;
    assign done     = (state_reg == scba_pkg::S_EXEC) && slot_free;

    // front half: classify the request and pick the address to read
    always_comb
    begin
        zero_in = (req_size == '0);
        big_in  = scba_pkg::USAGE_W'(req_size) >
                  scba_pkg::class_bytes(scba_pkg::CLS_W'(scba_pkg::NUM_CLASSES - 1));
        bad_in  = handle >= scba_pkg::HANDLE_W'(scba_pkg::TOTAL_BLOCKS);
        late_in = (deadline != '0) && (now_tick > deadline);
        if (kind == scba_pkg::KIND_FREE)
        begin
            cls_in = bad_in ? '0 : handle[scba_pkg::HANDLE_W-1:scba_pkg::IDX_W];
        end
        else
        begin
            cls_in = (zero_in || big_in) ? '0 : scba_pkg::pick_class(req_size);
        end
        head_in = head_reg[cls_in];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = scba_pkg::S_EXEC;
                end
            end
            scba_pkg::S_EXEC:
            begin
                if (done)
                begin
                    state_next = scba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scba_pkg::S_IDLE;
            end
        endcase
    end

    // back half: finish the request with the memory read data
    always_comb
    begin
        ok_alloc  = 1'b0;
        ok_free   = 1'b0;
        fail_inc  = 1'b0;
        status    = scba_pkg::ST_OK;
        grant     = '0;
        new_head  = head_l_reg;
        new_rcnt  = rcnt_l_reg;
        new_fresh = fresh_l_reg;
        if (kind_reg == scba_pkg::KIND_ALLOC)
        begin
            if (zero_reg)
            begin
                status = scba_pkg::ST_ZERO;
            end
            else if (big_reg)
            begin
                status   = scba_pkg::ST_BIG;
                fail_inc = 1'b1;
            end
            else if (rcnt_l_reg != '0)
            begin
                ok_alloc = 1'b1;
                grant    = (head_l_reg >= scba_pkg::HANDLE_W'(scba_pkg::TOTAL_BLOCKS)) ?
                           '0 : head_l_reg;
                new_head = mem_rsp.link_rdata;
                new_rcnt = rcnt_l_reg - 1'b1;
            end
            else if (fresh_l_reg != '0)
            begin
                ok_alloc  = 1'b1;
                new_fresh = fresh_l_reg - 1'b1;
                grant     = {cls_reg, new_fresh[scba_pkg::IDX_W-1:0]};
            end
            else
            begin
                status   = scba_pkg::ST_EMPTY;
                fail_inc = 1'b1;
            end
        end
        else
        begin
            if (bad_reg)
            begin
                status = scba_pkg::ST_BAD;
            end
            else if (!mem_rsp.busy_rdata)
            begin
                status = scba_pkg::ST_DOUBLE;
            end
            else
            begin
                ok_free  = 1'b1;
                new_head = h_reg;
                new_rcnt = rcnt_l_reg + 1'b1;
            end
        end

        if (ok_alloc)
        begin
            usage_next = usage_reg + scba_pkg::class_bytes(cls_reg);
        end
        else if (ok_free)
        begin
            usage_next = usage_reg - scba_pkg::class_bytes(cls_reg);
        end
        else
        begin
            usage_next = usage_reg;
        end
        peak_next = (usage_next > peak_reg) ? usage_next : peak_reg;
        fail_next = (fail_inc && (fail_reg != '1)) ? fail_reg + 1'b1 : fail_reg;
        miss_next = (ok_alloc && late_reg && (miss_reg != '1)) ? miss_reg + 1'b1 : miss_reg;

        res.status          = status;
        res.granted_handle  = grant;
        res.class_index     = cls_reg;
        res.deadline_missed = ok_alloc && late_reg;
        res.usage_bytes     = usage_next;
        res.peak_bytes      = peak_next;
        res.failure_total   = fail_next;
        res.miss_total      = miss_next;
        res_valid           = done;

        mem_req.rd_en      = accept;
        mem_req.rd_addr    = (kind == scba_pkg::KIND_FREE) ? handle :
                             ((head_in >= scba_pkg::HANDLE_W'(scba_pkg::TOTAL_BLOCKS)) ?
                              '0 : head_in);
        mem_req.link_we    = done && ok_free;
        mem_req.link_addr  = h_reg;
        mem_req.link_wdata = head_l_reg;
        mem_req.busy_we    = done && (ok_alloc || ok_free);
        mem_req.busy_addr  = ok_alloc ? grant : h_reg;
        mem_req.busy_wdata = ok_alloc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scba_pkg::S_IDLE;
            usage_reg <= '0;
            peak_reg  <= '0;
            fail_reg  <= '0;
            miss_reg  <= '0;
            for (int i = 0; i < scba_pkg::NUM_CLASSES; i++)
            begin
                head_reg[i]  <= '0;
                rcnt_reg[i]  <= '0;
                fresh_reg[i] <= scba_pkg::CNT_W'(scba_pkg::BLOCKS_PER_CLASS);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                usage_reg         <= usage_next;
                peak_reg          <= peak_next;
                fail_reg          <= fail_next;
                miss_reg          <= miss_next;
                head_reg[cls_reg]  <= new_head;
                rcnt_reg[cls_reg]  <= new_rcnt;
                fresh_reg[cls_reg] <= new_fresh;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            zero_reg    <= zero_in;
            big_reg     <= big_in;
            bad_reg     <= bad_in;
            late_reg    <= late_in;
            cls_reg     <= cls_in;
            h_reg       <= handle;
            head_l_reg  <= head_in;
            rcnt_l_reg  <= rcnt_reg[cls_in];
            fresh_l_reg <= fresh_reg[cls_in];
        end
    end

endmodule

[hw/rtl/size_class_block_allocator_top.sv]
`timescale 1ns / 1ps
// Top level of the size-class block allocator: stream ports and result register.
// Depends on scba_pkg, scba_block_mem and scba_ctrl.
//
// Usage: each transfer on the s_ side is one request, allocate (s_tuser = 0)
// or free (s_tuser = 1). Each request yields exactly one result transfer on
// the m_ side, in request order.
// The request and the block-memory read are registered when the request
// transfers; the result then enters the output register once that is free.
// Requests do not overlap: a new request is taken only after the previous
// one has finished its read then write of the block memory (one read port,
// one write port) and of the per-class list head.
// A new request is taken while a finished result still waits in the output
// register; if m_tready stays low, the request after that holds in its
// execute state until the register is free.
// Reset: all lists return to their untouched state, usage and counters
// clear. After reset the in-use map is swept one entry per cycle, so
// s_tready stays low until all 3072 entries have been swept.
module size_class_block_allocator_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // req_size[16:0], handle[28:17], deadline[60:29], now_tick[92:61], zero pad
    input  logic [scba_pkg::IN_W-1:0]      s_tdata,
    // kind[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], granted_handle[14:3], class_index[18:15], deadline_missed[19],
    // usage_bytes[44:20], peak_bytes[69:45], failure_total[101:70],
    // miss_total[133:102], zero pad
    output logic [scba_pkg::OUT_W-1:0]     m_tdata
);

    scba_pkg::mem_req_t mem_req;
    scba_pkg::mem_rsp_t mem_rsp;
    scba_pkg::result_t  res;
    logic               res_valid;
    logic               slot_free;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [scba_pkg::OUT_W-1:0]    m_data_reg;

    scba_block_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    scba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser[0]),
        .req_size  (s_tdata[scba_pkg::I_HDL-1:scba_pkg::I_SIZE]),
        .handle    (s_tdata[scba_pkg::I_DL-1:scba_pkg::I_HDL]),
        .deadline  (s_tdata[scba_pkg::I_NOW-1:scba_pkg::I_DL]),
        .now_tick  (s_tdata[scba_pkg::I_NOW+scba_pkg::TICK_W-1:scba_pkg::I_NOW]),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign slot_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_data_reg <= {{(scba_pkg::OUT_W - scba_pkg::O_END){1'b0}}, res};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hw/rtl/scba_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the size-class block allocator, bound to the top level.
// Depends on scba_pkg and size_class_block_allocator_top.
module scba_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [scba_pkg::OUT_W-1:0] m_tdata
);

    logic [scba_pkg::STAT_W-1:0]   stat;
    logic [scba_pkg::HANDLE_W-1:0] grant;
    logic                          miss;
    logic [scba_pkg::USAGE_W-1:0]  usage;
    logic [scba_pkg::USAGE_W-1:0]  peak;

    assign stat  = m_tdata[scba_pkg::O_GRANT-1:scba_pkg::O_STAT];
    assign grant = m_tdata[scba_pkg::O_CLS-1:scba_pkg::O_GRANT];
    assign miss  = m_tdata[scba_pkg::O_MISS];
    assign usage = m_tdata[scba_pkg::O_PEAK-1:scba_pkg::O_USE];
    assign peak  = m_tdata[scba_pkg::O_FAIL-1:scba_pkg::O_PEAK];

    // one request in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (stat <= scba_pkg::ST_DOUBLE))
        else $error("status code out of range");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (stat != scba_pkg::ST_OK) |-> (grant == '0) && !miss)
        else $error("error result carries a grant or a miss");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (peak >= usage))
        else $error("peak below current usage");

endmodule

bind size_class_block_allocator_top scba_checker u_scba_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb_size_class_block_allocator_top.sv]
`timescale 1ns / 1ps
// Testbench for size_class_block_allocator_top: directed and random allocate/free traffic,
// each result checked against a behavioral pool ledger. Depends on scba_pkg and the RTL.
module tb_size_class_block_allocator_top;
    import scba_pkg::*;

    localparam int MAX_BLOCK = MIN_BLOCK_BYTES << (NUM_CLASSES - 1);

    // Tracks the pool after every accepted request and holds the results still owed.
    class pool_ledger;
        logic [HANDLE_W-1:0] next_link [TOTAL_BLOCKS];
        logic [HANDLE_W-1:0] reuse_top [NUM_CLASSES];
        int unsigned         reuse_depth [NUM_CLASSES];
        int unsigned         untouched [NUM_CLASSES];
        bit                  in_use [TOTAL_BLOCKS];
        logic [USAGE_W:0]    bytes_live;
        logic [USAGE_W:0]    bytes_peak;
        logic [TOTAL_W-1:0]  fails;
        logic [TOTAL_W-1:0]  misses;
        result_t             outcomes_due [$];
        int                  errors;

        function new();
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                reuse_top[c]   = '0;
                reuse_depth[c] = 0;
                untouched[c]   = BLOCKS_PER_CLASS;
            end
            for (int h = 0; h < TOTAL_BLOCKS; h++)
            begin
                next_link[h] = '0;
                in_use[h]    = 1'b0;
            end
            bytes_live = '0;
            bytes_peak = '0;
            fails      = '0;
            misses     = '0;
            errors     = 0;
        endfunction

        // Apply one request to the pool and queue the result it must produce.
        function result_t book_request(logic kind, logic [SIZE_W-1:0] size,
                                       logic [HANDLE_W-1:0] hdl, logic [TICK_W-1:0] dl,
                                       logic [TICK_W-1:0] now);
            result_t r;
            int      c;
            int      g;
            r = '0;
            g = -1;
            if (kind == KIND_ALLOC)
            begin
                c = 0;
                while (c < NUM_CLASSES && (MIN_BLOCK_BYTES << c) < int'(size))
                    c++;
                if (size == '0)
                    r.status = ST_ZERO;
                else if (c >= NUM_CLASSES)
                begin
                    r.status = ST_BIG;
                    if (fails != '1)
                        fails++;
                end
                else if (reuse_depth[c] > 0)
                begin
                    // pop the most recently freed block
                    g = int'(reuse_top[c]);
                    reuse_top[c] = next_link[g];
                    reuse_depth[c]--;
                end
                else if (untouched[c] > 0)
                begin
                    untouched[c]--;
                    g = c * BLOCKS_PER_CLASS + int'(untouched[c]);
                end
                else
                begin
                    r.status      = ST_EMPTY;
                    r.class_index = CLS_W'(c);
                    if (fails != '1)
                        fails++;
                end
                if (g >= 0)
                begin
                    in_use[g] = 1'b1;
                    bytes_live = bytes_live + (MIN_BLOCK_BYTES << c);
                    if (bytes_live > bytes_peak)
                        bytes_peak = bytes_live;
                    r.status         = ST_OK;
                    r.granted_handle = HANDLE_W'(g);
                    r.class_index    = CLS_W'(c);
                    if (dl != '0 && now > dl)
                    begin
                        r.deadline_missed = 1'b1;
                        if (misses != '1)
                            misses++;
                    end
                end
            end
            else if (int'(hdl) >= TOTAL_BLOCKS)
                r.status = ST_BAD;
            else
            begin
                c = int'(hdl) / BLOCKS_PER_CLASS;
                r.class_index = CLS_W'(c);
                if (!in_use[hdl])
                    r.status = ST_DOUBLE;
                else
                begin
                    // push onto the class's recycled list
                    in_use[hdl]    = 1'b0;
                    next_link[hdl] = reuse_top[c];
                    reuse_top[c]   = hdl;
                    reuse_depth[c]++;
                    bytes_live = bytes_live - (MIN_BLOCK_BYTES << c);
                    r.status = ST_OK;
                end
            end
            r.usage_bytes   = bytes_live[USAGE_W-1:0];
            r.peak_bytes    = bytes_peak[USAGE_W-1:0];
            r.failure_total = fails;
            r.miss_total    = misses;
            outcomes_due.push_back(r);
            return r;
        endfunction

        task mismatch(string what, longint got, longint want);
            errors++;
            if (errors <= 40)
                $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        endtask

        task cmp(string what, longint got, longint want);
            if (got != want)
                mismatch(what, got, want);
        endtask

        task match_outcome(logic [OUT_W-1:0] word);
            result_t got;
            result_t want;
            got = word[O_END-1:0];
            if (outcomes_due.size() == 0)
            begin
                mismatch("result with nothing outstanding, status", got.status, 0);
                return;
            end
            want = outcomes_due.pop_front();
            cmp("status", got.status, want.status);
            cmp("granted_handle", got.granted_handle, want.granted_handle);
            cmp("class_index", got.class_index, want.class_index);
            cmp("deadline_missed", got.deadline_missed, want.deadline_missed);
            cmp("usage_bytes", got.usage_bytes, want.usage_bytes);
            cmp("peak_bytes", got.peak_bytes, want.peak_bytes);
            cmp("failure_total", got.failure_total, want.failure_total);
            cmp("miss_total", got.miss_total, want.miss_total);
            cmp("tdata pad", word[OUT_W-1:O_END], 0);
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [0:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    bit         hold_req;
    bit         calm;
    int         live_handles [$];
    pool_ledger ledger = new();

    size_class_block_allocator_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.match_outcome(m_tdata);
    end

    task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
                                input logic [HANDLE_W-1:0] hdl, input logic [TICK_W-1:0] dl,
                                input logic [TICK_W-1:0] now);
        result_t due;
        int      hits [$];
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, now, dl, hdl, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due = ledger.book_request(kind, size, hdl, dl, now);
        if (due.status == ST_OK)
        begin
            if (kind == KIND_ALLOC)
                live_handles.push_back(int'(due.granted_handle));
            else
            begin
                hits = live_handles.find_first_index(x) with (x == int'(hdl));
                if (hits.size() != 0)
                    live_handles.delete(hits[0]);
            end
        end
    endtask

    task automatic alloc_in_class(input int c);
        int                lo;
        logic [TICK_W-1:0] dl;
        logic [TICK_W-1:0] now;
        lo  = (c == 0) ? 1 : (MIN_BLOCK_BYTES << (c - 1)) + 1;
        dl  = ($urandom_range(0, 4) == 0) ? '0 : TICK_W'($urandom);
        now = ($urandom_range(0, 6) == 0) ? dl : TICK_W'($urandom);
        send_request(KIND_ALLOC, SIZE_W'($urandom_range(lo, MIN_BLOCK_BYTES << c)),
                     HANDLE_W'($urandom), dl, now);
    endtask

    task automatic free_live();
        int h;
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        send_request(KIND_FREE, SIZE_W'($urandom), HANDLE_W'(h), $urandom, $urandom);
    endtask

    task automatic random_request();
        int r;
        int h;
        r = $urandom_range(0, 99);
        if (r < 4)
            send_request(KIND_ALLOC, '0, HANDLE_W'($urandom), $urandom, $urandom);
        else if (r < 8)
            send_request(KIND_ALLOC, SIZE_W'($urandom_range(MAX_BLOCK + 1, 131071)),
                         HANDLE_W'($urandom), $urandom, $urandom);
        else if (r < 12)
            send_request(KIND_FREE, SIZE_W'($urandom),
                         HANDLE_W'($urandom_range(TOTAL_BLOCKS, 4095)), $urandom, $urandom);
        else if (r < 17)
        begin
            h = $urandom_range(0, TOTAL_BLOCKS - 1);
            while (ledger.in_use[h])
                h = $urandom_range(0, TOTAL_BLOCKS - 1);
            send_request(KIND_FREE, SIZE_W'($urandom), HANDLE_W'(h), $urandom, $urandom);
        end
        else if (live_handles.size() > 0 && (r < 55 || live_handles.size() > 120))
            free_live();
        else
            alloc_in_class($urandom_range(0, NUM_CLASSES - 1));
    endtask

    // Hold the request side until every owed result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.outcomes_due.size() != 0);
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        hold_req = 1'b0;
        calm     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boundaries of sizes, handles and deadlines
        send_request(KIND_ALLOC, '0, '0, '0, '0);
        send_request(KIND_ALLOC, 17'd1, '0, '0, '1);
        send_request(KIND_ALLOC, SIZE_W'(MIN_BLOCK_BYTES), '0, 32'd100, 32'd101);
        send_request(KIND_ALLOC, SIZE_W'(MIN_BLOCK_BYTES + 1), '0, 32'd100, 32'd100);
        send_request(KIND_ALLOC, SIZE_W'(MAX_BLOCK), '0, '1, '1);
        send_request(KIND_ALLOC, SIZE_W'(MAX_BLOCK + 1), '0, '0, '0);
        send_request(KIND_ALLOC, '1, '1, '1, '1);
        send_request(KIND_FREE, '0, '1, '0, '0);
        send_request(KIND_FREE, '0, HANDLE_W'(TOTAL_BLOCKS), '0, '0);
        send_request(KIND_FREE, '1, HANDLE_W'(TOTAL_BLOCKS - 1), '0, '0);
        send_request(KIND_FREE, '0, HANDLE_W'(TOTAL_BLOCKS - 1), '0, '0);
        send_request(KIND_FREE, '0, '0, '0, '0);
        send_request(KIND_FREE, '0, HANDLE_W'(BLOCKS_PER_CLASS - 1), '0, '0);
        send_request(KIND_ALLOC, 17'd20, '0, '0, '0);
        send_request(KIND_ALLOC, SIZE_W'(2 * MIN_BLOCK_BYTES), '0, 32'd1, '1);
        send_request(KIND_ALLOC, SIZE_W'(MIN_BLOCK_BYTES << 6), '0, '0, '0);
        send_request(KIND_ALLOC, SIZE_W'((MIN_BLOCK_BYTES << 6) + 1), '0, '0, '0);
        while (live_handles.size() != 0)
            free_live();
        settle();

        repeat (450)
            random_request();

        // long result-side hold-off while requests keep coming
        hold_req = 1'b1;
        repeat (40)
            random_request();

        // exhaust the largest class, then return every block
        repeat (BLOCKS_PER_CLASS + 6)
            alloc_in_class(NUM_CLASSES - 1);
        while (live_handles.size() != 0)
            free_live();
        repeat (20)
            alloc_in_class(NUM_CLASSES - 1);
        repeat (20)
            alloc_in_class(0);
        settle();

        repeat (150)
            random_request();
        calm = 1'b1;
        repeat (300)
            random_request();

        s_tvalid <= 1'b0;
        guard = 0;
        while (ledger.outcomes_due.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (ledger.outcomes_due.size() != 0)
            ledger.mismatch("results never delivered", ledger.outcomes_due.size(), 0);
        if (ledger.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/scba_pkg.sv
hw/rtl/scba_block_mem.sv
hw/rtl/scba_ctrl.sv
hw/rtl/size_class_block_allocator_top.sv
hw/rtl/scba_checker.sv
bench/tb_size_class_block_allocator_top.sv
